[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, sampled on clk_i, masked while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge out of reset
`define LRUPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every edge out of reset
`define LRUPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared constants and types of the lru page replacement block
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int PAGE_W     = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_W      = 5;
  localparam int FILL_W     = $clog2(MAX_FRAMES + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic upd;
    logic hit_any;
    logic evict;
    logic below_last;
    logic is_last;
    logic is_free;
  } cell_ctl_t;

endpackage

[rtl/core/lrupr_in_if.sv]
// ----------------------------------------------------------------------------
// lrupr_in_if
// reference channel: one page number per item
// ----------------------------------------------------------------------------
interface lrupr_in_if;
  logic                      valid;
  logic                      ready;
  logic [lrupr_pkg::PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

[rtl/core/lrupr_out_if.sv]
// ----------------------------------------------------------------------------
// lrupr_out_if
// result channel: hit flag, eviction and running hit count per item
// ----------------------------------------------------------------------------
interface lrupr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         evict_valid;
  logic [lrupr_pkg::PAGE_W-1:0] evicted_page;
  logic [lrupr_pkg::CNT_W-1:0]  hit_total;

  modport source (output valid, output hit, output evict_valid, output evicted_page,
                  output hit_total, input ready);
  modport sink   (input valid, input hit, input evict_valid, input evicted_page,
                  input hit_total, output ready);
endinterface

[rtl/core/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative lru replacement over a programmable number of frames
// ----------------------------------------------------------------------------
// Takes one page reference per cycle and registers one result item per reference
// for the next cycle; the block keeps accepting while the result is taken in the
// same cycle. The recency stack is a row of cells, least recent in cell 0: all
// cells compare the page at once, a match flag ripples up the row, and each cell
// from the match up (or every cell on an eviction) takes its upper neighbor's
// page in the same edge while the top occupied cell, or on a fill the first free
// cell, loads the new page. The user must write active_frames via cfg_we_i only
// while idle (unenforced); zero acts as one, values above the frame count saturate.
module lru_page_replacement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_data_i,
  lrupr_in_if.sink                      in_i,
  lrupr_out_if.source                   out_o
);

`include "assert_macros.svh"

  localparam int N = lrupr_pkg::MAX_FRAMES;

  logic [lrupr_pkg::CFG_W-1:0]  active_q;
  logic [lrupr_pkg::FILL_W-1:0] filled_q, filled_d, lim;
  logic [lrupr_pkg::CNT_W-1:0]  hit_cnt_q, hit_cnt_d;
  logic                         out_valid_q;
  logic                         hit_q, evict_q;
  logic [lrupr_pkg::PAGE_W-1:0] evicted_q;

  lrupr_pkg::page_t     page;
  lrupr_pkg::page_t     entry [N];
  lrupr_pkg::cell_ctl_t ctl   [N];
  logic [N-1:0]         match;
  logic [N:0]           seen;
  logic                 accept, hit_any, evict;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign page       = lrupr_pkg::PAGE_BITS'(in_i.page);
  assign hit_any    = |match;
  assign seen[0]    = 1'b0;

  always_comb begin
    if (active_q == '0) begin
      lim = lrupr_pkg::FILL_W'(1);
    end else if (32'(active_q) > N) begin
      lim = lrupr_pkg::FILL_W'(N);
    end else begin
      lim = lrupr_pkg::FILL_W'(active_q);
    end
  end

  assign evict = !hit_any && (filled_q >= lim);

  for (genvar k = 0; k < N; k++) begin : g_cell
    always_comb begin
      ctl[k].upd        = accept;
      ctl[k].hit_any    = hit_any;
      ctl[k].evict      = evict;
      ctl[k].below_last = lrupr_pkg::FILL_W'(k + 1) < filled_q;
      ctl[k].is_last    = lrupr_pkg::FILL_W'(k + 1) == filled_q;
      ctl[k].is_free    = lrupr_pkg::FILL_W'(k) == filled_q;
    end

    lrupr_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[k]),
      .occupied_i   (lrupr_pkg::FILL_W'(k) < filled_q),
      .page_i       (page),
      .next_entry_i (entry[(k + 1 < N) ? k + 1 : k]),
      .seen_i       (seen[k]),
      .match_o      (match[k]),
      .seen_o       (seen[k+1]),
      .entry_o      (entry[k])
    );
  end

  always_comb begin
    filled_d  = filled_q;
    hit_cnt_d = hit_cnt_q;
    if (accept) begin
      if (hit_any) begin
        if (hit_cnt_q != lrupr_pkg::CNT_MAX) begin
          hit_cnt_d = hit_cnt_q + 1'b1;
        end
      end else if (!evict) begin
        filled_d = filled_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= lrupr_pkg::CFG_RESET;
      filled_q    <= '0;
      hit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
      filled_q  <= filled_d;
      hit_cnt_q <= hit_cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q     <= hit_any;
      evict_q   <= evict;
      evicted_q <= evict ? lrupr_pkg::PAGE_W'(entry[0]) : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.hit          = hit_q;
  assign out_o.evict_valid  = evict_q;
  assign out_o.evicted_page = evicted_q;
  assign out_o.hit_total    = hit_cnt_q;

  // resident pages are unique
  `LRUPR_ASSERT(a_one_match, $onehot0(match), "page resident in more than one frame")
  `LRUPR_ASSERT(a_fill_bound, 32'(filled_q) <= N, "resident count beyond frame count")
  `LRUPR_ASSERT_IMP(a_evict_keeps_fill, accept && evict, filled_q == $past(filled_q),
                    "eviction changed resident count")
  `LRUPR_ASSERT_IMP(a_fill_grows, accept && !hit_any && !evict,
                    filled_q == $past(filled_q) + 1'b1, "free frame fill did not count")

endmodule

[rtl/core/lrupr_cell.sv]
// ----------------------------------------------------------------------------
// lrupr_cell
// one slot of the recency stack: compares, shifts down or loads the new page
// ----------------------------------------------------------------------------
module lrupr_cell (
  input  logic                 clk_i,
  input  lrupr_pkg::cell_ctl_t ctl_i,
  input  logic                 occupied_i,
  input  lrupr_pkg::page_t     page_i,
  input  lrupr_pkg::page_t     next_entry_i,
  input  logic                 seen_i,
  output logic                 match_o,
  output logic                 seen_o,
  output lrupr_pkg::page_t     entry_o
);

  lrupr_pkg::page_t entry_q, entry_d;
  logic             shift, load;

  assign match_o = occupied_i && (entry_q == page_i);
  assign seen_o  = seen_i || match_o;
  assign entry_o = entry_q;

  always_comb begin
    shift = ctl_i.upd && ctl_i.below_last && (ctl_i.evict || (ctl_i.hit_any && seen_o));
    load  = ctl_i.upd && (((ctl_i.hit_any || ctl_i.evict) && ctl_i.is_last) ||
                          (!ctl_i.hit_any && !ctl_i.evict && ctl_i.is_free));
    entry_d = entry_q;
    if (shift) begin
      entry_d = next_entry_i;
    end else if (load) begin
      entry_d = page_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[dv/lru_page_replacement_tb.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// Drives page references into the lru replacement block and predicts each
// result with its own recency stack, resident count and hit counter. Covers
// the frame count extremes, shrinking the frame count below the resident
// pages, long output stalls and sender pauses.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PRINT_LIMIT  = 50;

  typedef struct packed {
    logic                         hit;
    logic                         evict_valid;
    logic [lrupr_pkg::PAGE_W-1:0] evicted_page;
    logic [lrupr_pkg::CNT_W-1:0]  hit_total;
  } lookup_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [lrupr_pkg::CFG_W-1:0] cfg_data_i;

  lrupr_in_if  in_ch ();
  lrupr_out_if out_ch ();

  lru_page_replacement u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predictor state
  lrupr_pkg::page_t            lru_stack [lrupr_pkg::MAX_FRAMES];
  int unsigned                 frames_used;
  logic [lrupr_pkg::CNT_W-1:0] hits_seen;
  logic [lrupr_pkg::CFG_W-1:0] frames_cfg;

  lookup_t          lookup_q [$];
  int unsigned      err_count;
  int unsigned      results_seen;
  int unsigned      cycle_count;
  int               rx_hold;
  bit               idle_on;
  lrupr_pkg::page_t ws_base;
  int               ws_span;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic int frame_cap();
    if (frames_cfg == '0) return 1;
    if (frames_cfg > lrupr_pkg::MAX_FRAMES) return lrupr_pkg::MAX_FRAMES;
    return int'(frames_cfg);
  endfunction

  function automatic lookup_t lru_lookup(input lrupr_pkg::page_t pg);
    lookup_t r;
    int      limit;
    int      pos;
    bit      found;
    r = '0;
    limit = frame_cap();
    found = 1'b0;
    pos = 0;
    for (int k = 0; k < frames_used; k++) begin
      if (!found && lru_stack[k] == pg) begin
        found = 1'b1;
        pos = k;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (hits_seen != lrupr_pkg::CNT_MAX) hits_seen++;
      for (int k = pos; k + 1 < frames_used; k++) lru_stack[k] = lru_stack[k+1];
      lru_stack[frames_used-1] = pg;
    end else if (frames_used < limit) begin
      lru_stack[frames_used] = pg;
      frames_used++;
    end else begin
      r.evict_valid = 1'b1;
      r.evicted_page = lru_stack[0];
      for (int k = 0; k + 1 < frames_used; k++) lru_stack[k] = lru_stack[k+1];
      lru_stack[frames_used-1] = pg;
    end
    r.hit_total = hits_seen;
    return r;
  endfunction

  function automatic lrupr_pkg::page_t pick_page();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) return ws_base + lrupr_pkg::page_t'($urandom_range(0, ws_span));
    return lrupr_pkg::page_t'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_seen, what, got, want);
  endtask

  // leaves valid high after acceptance; a drain, or a random pause in the next send, lowers it
  task automatic send_page(input lrupr_pkg::page_t pg);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.page  <= pg;
    do @(posedge clk_i); while (!in_ch.ready);
    lookup_q.insert(lookup_q.size(), lru_lookup(pg));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    frames_cfg = value;
  endtask

  task automatic set_working_set(input int extra);
    ws_base = lrupr_pkg::page_t'($urandom);
    ws_span = frame_cap() + extra;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_page(pick_page());
  endtask

  // extremes of the page field, zero and oversize frame counts, shrink below resident
  task automatic test_directed();
    lrupr_pkg::page_t pg;
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hAAAA);
    send_page(16'h5555);
    drain_results();
    write_frames(lrupr_pkg::CFG_W'(0));
    send_page(16'h1234);
    send_page(16'h0000);
    drain_results();
    write_frames(lrupr_pkg::CFG_W'(31));
    for (int i = 0; i < 17; i++) begin
      pg = lrupr_pkg::page_t'(16'h8000 + i * 16'h0101);
      send_page(pg);
    end
    drain_results();
  endtask

  task automatic test_frame_sweep();
    logic [lrupr_pkg::CFG_W-1:0] sweep [6];
    sweep[0] = lrupr_pkg::CFG_W'(1);
    sweep[1] = lrupr_pkg::CFG_W'(lrupr_pkg::MAX_FRAMES);
    sweep[2] = lrupr_pkg::CFG_W'(2);
    sweep[3] = lrupr_pkg::CFG_W'(17);
    sweep[4] = lrupr_pkg::CFG_W'(lrupr_pkg::CFG_RESET);
    sweep[5] = lrupr_pkg::CFG_W'(0);
    foreach (sweep[i]) begin
      write_frames(sweep[i]);
      set_working_set($urandom_range(0, 3));
      send_random(40);
      drain_results();
    end
  endtask

  // output held off long enough for the block to stall its input
  task automatic test_output_stall();
    write_frames(lrupr_pkg::CFG_W'(6));
    set_working_set(3);
    rx_hold = 250;
    send_random(40);
    drain_results();
  endtask

  task automatic test_sender_pause();
    write_frames(lrupr_pkg::CFG_W'(8));
    set_working_set(2);
    send_random(15);
    drain_results();
    send_random(15);
    drain_results();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      write_frames(lrupr_pkg::CFG_W'($urandom_range(0, 31)));
      set_working_set($urandom_range(0, 6));
      send_random(100);
      drain_results();
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    write_frames(lrupr_pkg::CFG_W'(lrupr_pkg::MAX_FRAMES));
    set_working_set(4);
    send_random(200);
    drain_results();
  endtask

  // result checker
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (lookup_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = lookup_q[0];
        lookup_q.delete(0);
        if (out_ch.hit !== want.hit)
          report_mismatch("hit", out_ch.hit, want.hit);
        if (out_ch.evict_valid !== want.evict_valid)
          report_mismatch("evict_valid", out_ch.evict_valid, want.evict_valid);
        if (out_ch.evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", out_ch.evicted_page, want.evicted_page);
        if (out_ch.hit_total !== want.hit_total)
          report_mismatch("hit_total", out_ch.hit_total, want.hit_total);
      end
    end
  end

  // output ready with random stalls and long hold-offs
  initial begin : rx_ready
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_page_replacement_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.page   = '0;
    err_count    = 0;
    results_seen = 0;
    cycle_count  = 0;
    rx_hold      = 0;
    idle_on      = 1'b1;
    ws_base      = '0;
    ws_span      = 1;
    frames_used  = 0;
    hits_seen    = '0;
    frames_cfg   = lrupr_pkg::CFG_RESET;
    foreach (lru_stack[i]) lru_stack[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_frame_sweep();
    test_output_stall();
    test_sender_pause();
    test_random_phases();
    test_back_to_back();

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("lru_page_replacement_tb: done, clean");
    end else begin
      $display("lru_page_replacement_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_in_if.sv
rtl/core/lrupr_out_if.sv
rtl/core/lrupr_cell.sv
rtl/core/lru_page_replacement.sv
dv/lru_page_replacement_tb.sv
